### rtl/core/pcs_pkg.sv
// Package for the percentile contrast stretch block.
// Transaction types, sizes, constants and the control state type.
// No dependencies.
`timescale 1ns / 1ps
package pcs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int BIN_AW      = SAMPLE_BITS;
  localparam int CNT_W       = 19;
  localparam int CLIP_W      = 14;
  localparam int LEVEL_W     = 17;
  localparam int DIV_NW      = 33;
  localparam int DIV_DW      = 17;
  localparam int STEP_W      = 6;

  // rank = floor(p / 10000) = floor(floor(p / 16) / 625), exact reciprocal for 29-bit p / 16
  localparam int RANK_PW  = CNT_W + CLIP_W;
  localparam int RECIP_W  = 30;
  localparam int RECIP_SH = 39;
  localparam int RANK_MW  = RANK_PW - 4 + RECIP_W;
  localparam int RANK_QW  = RANK_MW - RECIP_SH;

  localparam logic [CNT_W-1:0]   MAX_SAMPLES = CNT_W'(262144);
  localparam logic [RECIP_W-1:0] RECIP_625   = RECIP_W'(879609303);
  localparam logic [15:0]        FULL_SCALE  = 16'd65280;
  localparam logic [CLIP_W-1:0]  CLIP_RESET  = CLIP_W'(100);

  localparam logic KIND_COLLECT = 1'b0;
  localparam logic KIND_MAP     = 1'b1;
  localparam logic CFG_LOW      = 1'b0;
  localparam logic CFG_HIGH     = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic                      last_res;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COL,
    S_R1,
    S_R1W,
    S_R2,
    S_R2W,
    S_R2C,
    S_SWEEP,
    S_MAP,
    S_MAPW,
    S_OUT,
    S_CLR
  } state_t;

endpackage

### rtl/core/percentile_contrast_stretch.sv
// Top level of the percentile contrast stretch: histogram memory, rank search, mapping.
// Depends on pcs_pkg and pcs_div.
//
//   port group      dir  handshake           payload
//   in_*            in   in_valid/in_stall   in_t  {kind, sample, last}
//   out_*           out  out_valid/out_stall out_t {level, last_res}
//   cfg_*           in   cfg_we              cfg_index, cfg_data
//
// Collect transaction: read-modify-write of one histogram bin, dropped at MAX_SAMPLES.
// Map transaction with levels known: divider used unless the result is clipped or degenerate.
// First map after collecting: the two ranks (reciprocal multiply) in S_R1 to S_R2C,
// then a histogram sweep over up to 65536 bins, read one at a time through the single read port.
// Reset and a map transaction with last set start a clearing pass over all 65536 bins.
// The output register lets a new transaction enter while a result is stalled.
`timescale 1ns / 1ps
module percentile_contrast_stretch import pcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CLIP_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [CNT_W-1:0] hist_mem [2**BIN_AW];
  logic [BIN_AW-1:0] rd_addr, wr_addr;
  logic [CNT_W-1:0]  rd_q, wr_data;
  logic              wr_en;

  in_t                item;
  logic [CNT_W-1:0]   count;
  logic signed [15:0] low_lv, high_lv;
  logic               lv_ready;
  logic [CLIP_W-1:0]  low_clip, high_clip;
  logic [CNT_W-1:0]   r1, r2;
  logic [RANK_PW-1:0] rank_prod;
  logic [RANK_MW-1:0] rank_mul;
  logic [RANK_QW-1:0] rank_q;
  logic [BIN_AW:0]    sweep_addr;
  logic               sweep_dv;
  logic [BIN_AW-1:0]  sweep_didx;
  logic [CNT_W-1:0]   acc, acc_new;
  logic               lo_found, hi_found, lo_hit, hi_hit, sweep_end;
  logic [BIN_AW-1:0]  clr_addr;
  logic signed [LEVEL_W-1:0] res_level;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_q;
  logic [DIV_DW-1:0] div_den;
  logic [15:0]       diff;
  logic [31:0]       prod;
  logic              degen, below, above;
  logic [CNT_W-1:0]  n_m1;
  logic              out_free;
  logic signed [15:0] bin_level;

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign acc_new   = acc + rd_q;
  assign lo_hit    = sweep_dv && !lo_found && (acc_new > r1);
  assign hi_hit    = sweep_dv && !hi_found && (acc_new > r2);
  assign sweep_end = sweep_dv && (lo_found || lo_hit) && (hi_found || hi_hit);
  assign bin_level = {~sweep_didx[15], sweep_didx[14:0]};
  assign n_m1      = count - 1'b1;
  assign degen     = high_lv <= low_lv;
  assign below     = item.sample < low_lv;
  assign above     = item.sample > high_lv;
  assign diff      = 16'(item.sample - low_lv);
  assign prod      = diff * FULL_SCALE;
  assign rank_mul  = RANK_MW'(rank_prod[RANK_PW-1:4]) * RANK_MW'(RECIP_625);

  always_ff @(posedge clk) begin
    if (wr_en) hist_mem[wr_addr] <= wr_data;
    rd_q <= hist_mem[rd_addr];
  end

  pcs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == KIND_COLLECT) begin
            state_next = (count < MAX_SAMPLES) ? S_COL : S_IDLE;
          end else if (lv_ready || count == '0) begin
            state_next = S_MAP;
          end else begin
            state_next = S_R1;
          end
        end
      end
      S_COL:   state_next = S_IDLE;
      S_R1:    state_next = S_R1W;
      S_R1W:   state_next = S_R2;
      S_R2:    state_next = S_R2W;
      S_R2W:   state_next = S_R2C;
      S_R2C:   state_next = S_SWEEP;
      S_SWEEP: if (sweep_end) state_next = S_MAP;
      S_MAP:   state_next = (degen || below || above) ? S_OUT : S_MAPW;
      S_MAPW:  if (div_done) state_next = S_OUT;
      S_OUT:   if (out_free) state_next = item.last ? S_CLR : S_IDLE;
      S_CLR:   if (clr_addr == '1) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr   = sweep_addr[BIN_AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = item.sample ^ 16'h8000;
    wr_data   = rd_q + 1'b1;
    div_start = 1'b0;
    div_num   = {1'b0, prod};
    div_den   = {1'b0, 16'(high_lv - low_lv)};
    case (state)
      S_IDLE: rd_addr = in_data.sample ^ 16'h8000;
      S_COL:  wr_en = 1'b1;
      S_MAP:  div_start = !(degen || below || above);
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      count     <= '0;
      low_lv    <= '0;
      high_lv   <= '0;
      lv_ready  <= 1'b0;
      low_clip  <= CLIP_RESET;
      high_clip <= CLIP_RESET;
      out_valid <= 1'b0;
      sweep_dv  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CFG_LOW) low_clip <= cfg_data;
        else high_clip <= cfg_data;
      end
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      sweep_dv <= (state == S_SWEEP) && !sweep_addr[BIN_AW];
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.kind == KIND_COLLECT) begin
              lv_ready <= 1'b0;
            end else if (!lv_ready && count == '0) begin
              low_lv   <= '0;
              high_lv  <= '0;
              lv_ready <= 1'b1;
            end
          end
        end
        S_COL: count <= count + 1'b1;
        S_SWEEP: begin
          if (sweep_end) lv_ready <= 1'b1;
          if (lo_hit) low_lv <= bin_level;
          if (hi_hit) high_lv <= bin_level;
        end
        S_OUT: clr_addr <= '0;
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          count    <= '0;
          low_lv   <= '0;
          high_lv  <= '0;
          lv_ready <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) item <= in_data;
    if (state == S_R1) rank_prod <= RANK_PW'(count) * RANK_PW'(low_clip);
    if (state == S_R1W || state == S_R2W) rank_q <= rank_mul[RANK_MW-1:RECIP_SH];
    if (state == S_R2) begin
      rank_prod <= RANK_PW'(count) * RANK_PW'(high_clip);
      r1        <= (rank_q > RANK_QW'(n_m1)) ? n_m1 : rank_q[CNT_W-1:0];
    end
    if (state == S_R2C) begin
      r2         <= (rank_q > RANK_QW'(n_m1)) ? '0 : n_m1 - rank_q[CNT_W-1:0];
      sweep_addr <= '0;
      acc        <= '0;
      lo_found   <= 1'b0;
      hi_found   <= 1'b0;
    end
    if (state == S_SWEEP) begin
      if (!sweep_addr[BIN_AW]) sweep_addr <= sweep_addr + 1'b1;
      sweep_didx <= sweep_addr[BIN_AW-1:0];
      if (sweep_dv) acc <= acc_new;
      if (lo_hit) lo_found <= 1'b1;
      if (hi_hit) hi_found <= 1'b1;
    end
    if (state == S_MAP) begin
      if (degen)      res_level <= LEVEL_W'(high_lv);
      else if (below) res_level <= '0;
      else            res_level <= {1'b0, FULL_SCALE};
    end
    if (state == S_MAPW && div_done) res_level <= div_q[LEVEL_W-1:0];
    if (state == S_OUT && out_free) begin
      out_data.level    <= res_level;
      out_data.last_res <= item.last;
    end
  end

endmodule

### rtl/core/pcs_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Uses pcs_pkg for operand widths.
`timescale 1ns / 1ps
module pcs_div import pcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIV_DW-1:0] dvs;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem, quo[DIV_NW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !start && (step == STEP_W'(DIV_NW - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_NW - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      dvs <= den;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? DIV_DW'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_DW-1:0];
      quo <= {quo[DIV_NW-2:0], fits};
    end
  end

endmodule

### tb/tb_percentile_contrast_stretch.sv
// Testbench for percentile_contrast_stretch: frames of collect and map transactions
// against a built-in histogram/rank predictor, with random idling on both sides.
// Depends on pcs_pkg and the percentile_contrast_stretch RTL.
`timescale 1ns / 1ps
module tb_percentile_contrast_stretch;
  import pcs_pkg::*;

  localparam int  BINS         = 1 << SAMPLE_BITS;
  localparam int  OFFSET       = 1 << (SAMPLE_BITS - 1);
  localparam int  SCALE        = 65280;
  localparam int  SETTLE       = 70000;
  localparam longint LIMIT     = 8000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_LOW;
  logic [CLIP_W-1:0] cfg_data = '0;

  percentile_contrast_stretch uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned hist_bins [BINS];
  int unsigned pixel_total;
  int          black_level;
  int          white_level;
  bit          levels_known;
  int unsigned clip_lo = CLIP_RESET;
  int unsigned clip_hi = CLIP_RESET;
  out_t        level_queue [$];

  int     errors = 0;
  int     sent = 0;
  int     results = 0;
  longint cycles = 0;
  bit     burst = 1'b0;
  int     stall_left = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch #%0d: %s got %0d expected %0d (result %0d)", errors + 1, what, got,
             want, results);
    errors++;
  endtask

  task automatic clear_bins();
    foreach (hist_bins[i]) hist_bins[i] = 0;
    pixel_total = 0;
    black_level = 0;
    white_level = 0;
    levels_known = 1'b0;
  endtask

  function automatic int rank_sample(input int unsigned rank);
    longint acc;
    int b;
    acc = 0;
    for (b = 0; b < BINS; b++) begin
      acc += hist_bins[b];
      if (acc > rank) break;
    end
    if (b >= BINS) b = BINS - 1;
    return b - OFFSET;
  endfunction

  task automatic stretch_sample(input in_t t);
    longint n, r1, cut, r2;
    int x, lvl;
    out_t r;
    x = t.sample;
    if (t.kind == KIND_COLLECT) begin
      if (pixel_total < MAX_SAMPLES) begin
        hist_bins[x + OFFSET]++;
        pixel_total++;
      end
      levels_known = 1'b0;
      return;
    end
    if (!levels_known) begin
      n = pixel_total;
      if (n == 0) begin
        black_level = 0;
        white_level = 0;
      end else begin
        r1 = (n * clip_lo) / 10000;
        if (r1 > n - 1) r1 = n - 1;
        cut = (n * clip_hi) / 10000;
        r2 = (cut > n - 1) ? 0 : n - 1 - cut;
        black_level = rank_sample(r1);
        white_level = rank_sample(r2);
      end
      levels_known = 1'b1;
    end
    if (white_level <= black_level) lvl = white_level;
    else if (x < black_level) lvl = 0;
    else if (x > white_level) lvl = SCALE;
    else lvl = int'((longint'(x - black_level) * SCALE) / (white_level - black_level));
    r.level = lvl[LEVEL_W-1:0];
    r.last_res = t.last;
    level_queue.push_back(r);
    if (t.last) clear_bins();
  endtask

  task automatic send_item(input logic kind, input logic signed [15:0] s, input logic last);
    int gap, p;
    in_t t;
    t.kind = kind;
    t.sample = s;
    t.last = last;
    p = $urandom_range(99);
    gap = burst ? 0 : (p < 50) ? 0 : (p < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    stretch_sample(t);
    sent++;
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (level_queue.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    go_quiet();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_clip(input logic idx, input int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CLIP_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LOW) clip_lo = v[CLIP_W-1:0];
    else clip_hi = v[CLIP_W-1:0];
  endtask

  function automatic logic signed [15:0] pick_sample(input int center, input int spread);
    int v;
    if ($urandom_range(99) < 30) return 16'($urandom());
    v = center + $urandom_range(0, 2 * spread) - spread;
    return v[15:0];
  endfunction

  task automatic random_frame(input int n_col, input int n_map, input bit pause_mid);
    int center, spread;
    center = $urandom_range(0, 65535) - OFFSET;
    spread = $urandom_range(1, 4000);
    for (int i = 0; i < n_col; i++)
      send_item(KIND_COLLECT, pick_sample(center, spread), $urandom_range(7) == 0);
    for (int i = 0; i < n_map; i++) begin
      if (pause_mid && i == n_map / 2) begin
        go_quiet();
        wait_drained();
      end
      send_item(KIND_MAP, pick_sample(center, spread), i == n_map - 1);
    end
  endtask

  task automatic test_directed_extremes();
    logic signed [15:0] vals [8] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0100,
                                     16'shff00, 16'sh5555, 16'shaaaa, 16'sh0064};
    foreach (vals[i]) send_item(KIND_COLLECT, vals[i], i == 7);
    foreach (vals[i]) send_item(KIND_MAP, vals[i], 1'b0);
    send_item(KIND_MAP, 16'sh0080, 1'b1);
    settle();
  endtask

  task automatic test_zero_clip_burst();
    write_clip(CFG_LOW, 0);
    write_clip(CFG_HIGH, 0);
    burst = 1'b1;
    random_frame(40, 20, 1'b0);
    burst = 1'b0;
    settle();
  endtask

  // saturated ranks, map on an empty store, then collect while mapping
  task automatic test_saturated_and_empty();
    write_clip(CFG_LOW, 16383);
    write_clip(CFG_HIGH, 16383);
    send_item(KIND_MAP, 16'sh1234, 1'b0);
    send_item(KIND_MAP, 16'sh8000, 1'b0);
    for (int i = 0; i < 12; i++) send_item(KIND_COLLECT, 16'($urandom()), 1'b0);
    send_item(KIND_MAP, 16'sh0000, 1'b0);
    send_item(KIND_COLLECT, 16'sh7fff, 1'b0);
    send_item(KIND_MAP, 16'sh7fff, 1'b1);
    settle();
  endtask

  task automatic test_random_frames();
    for (int f = 0; f < 5; f++) begin
      write_clip(CFG_LOW, $urandom_range(0, 2500));
      write_clip(CFG_HIGH, (f == 4) ? 10000 : $urandom_range(0, 2500));
      random_frame($urandom_range(30, 50), $urandom_range(15, 25), f == 0);
      settle();
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!burst && $urandom_range(99) < 15) begin
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (level_queue.size() == 0) begin
        report("unexpected transaction, level", out_data.level, 0);
      end else begin
        want = level_queue.pop_front();
        if (out_data.level !== want.level) report("level", out_data.level, want.level);
        if (out_data.last_res !== want.last_res)
          report("last_res", out_data.last_res, want.last_res);
      end
      results++;
    end
  end

  initial begin
    clear_bins();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    test_directed_extremes();
    test_zero_clip_burst();
    test_saturated_and_empty();
    test_random_frames();
    $display("covered %0d transactions in, %0d results out, over 8 frames", sent, results);
    $display("clip extremes, empty and saturated ranks, collect during map, bursts, stalls");
    if (errors == 0 && level_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, level_queue.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
